[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[src/msa_pkg.sv]
package msa_pkg;

	localparam int SAMPLE_BITS    = 12;
	localparam int CHAN_BITS      = 5;
	localparam int SLOT_BITS      = 5;
	localparam int SUM_BITS       = 20;
	localparam int COUNT_BITS     = 8;
	localparam int SPA_BITS       = 9;
	localparam int CC_BITS        = 6;
	localparam int CFG_DATA_BITS  = 9;
	localparam int S_DATA_BITS    = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int M_DATA_BITS    = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int M_USER_BITS    = CHAN_BITS + SLOT_BITS;
	localparam int DIGIT_BITS     = 4;
	localparam int SUM_DIGITS     = SUM_BITS / DIGIT_BITS;
	localparam int DIGIT_CNT_BITS = $clog2(SUM_DIGITS);
	localparam int DIV_STEPS      = SUM_BITS;
	localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);
	localparam int MAX_AVERAGE    = 256;
	localparam int MAX_SLOTS      = 32;

	typedef enum logic [0:0] {
		REG_SAMPLES_PER_AVERAGE = 1'b0,
		REG_CHANNEL_COUNT       = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_DIVIDE
	} state_t;

	typedef struct packed {
		logic load;
		logic clear;
	} acc_cmd_t;

endpackage

[src/multichannel_sample_averager.sv]
// s_tready is high only in idle: a new input is not taken until the last one is summed and,
// on a block's last sample, until the average is divided out and loaded to the output,
// which waits while m_tready holds back a waiting result. The pace is set by the 4-bit
// serial accumulator (5 digits) and the 1-bit-per-cycle divider (20 steps).
// Reset: arst_n clears sum, counters, slot index and output valid; both registers read 1.
`include "assert_macros.svh"

module multichannel_sample_averager (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [msa_pkg::S_DATA_BITS-1:0]    s_tdata,   // sample
	input  logic [msa_pkg::CHAN_BITS-1:0]      s_tuser,   // channel
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [msa_pkg::M_DATA_BITS-1:0]    m_tdata,   // average
	output logic [msa_pkg::M_USER_BITS-1:0]    m_tuser,   // slot, avg_channel
	output logic                               m_tlast,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [msa_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
	import msa_pkg::*;

	logic [SPA_BITS-1:0]    spa_q;
	logic [CC_BITS-1:0]     cc_q;
	state_t                 state_q;
	state_t                 state_d;
	logic [COUNT_BITS-1:0]  taken_q;
	logic [SLOT_BITS-1:0]   slot_q;
	logic [CHAN_BITS-1:0]   chan_q;
	logic                   m_tvalid_q;
	logic [SAMPLE_BITS-1:0] avg_q;
	logic [CHAN_BITS-1:0]   ochan_q;
	logic [SLOT_BITS-1:0]   oslot_q;
	logic                   olast_q;

	logic [SPA_BITS-1:0]    block_len;
	logic [CC_BITS-1:0]     run_len;
	logic                   block_end;
	logic                   run_end;
	acc_cmd_t               acc_cmd;
	logic                   acc_busy;
	logic [SUM_BITS-1:0]    acc_sum;
	logic                   div_start;
	logic                   div_busy;
	logic [SUM_BITS-1:0]    quotient;
	logic                   out_load;
	logic [SAMPLE_BITS-1:0] average;

	always_comb begin
		if (spa_q == '0) begin
			block_len = SPA_BITS'(1);
		end else if (spa_q > SPA_BITS'(MAX_AVERAGE)) begin
			block_len = SPA_BITS'(MAX_AVERAGE);
		end else begin
			block_len = spa_q;
		end
		if (cc_q == '0) begin
			run_len = CC_BITS'(1);
		end else if (cc_q > CC_BITS'(MAX_SLOTS)) begin
			run_len = CC_BITS'(MAX_SLOTS);
		end else begin
			run_len = cc_q;
		end
	end

	assign block_end = ({1'b0, taken_q} + SPA_BITS'(1)) >= block_len;
	assign run_end   = ({1'b0, slot_q} + CC_BITS'(1)) >= run_len;
	assign average   = (|quotient[SUM_BITS-1:SAMPLE_BITS]) ? '1 : quotient[SAMPLE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spa_q <= SPA_BITS'(1);
			cc_q  <= CC_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SAMPLES_PER_AVERAGE: spa_q <= cfg_wdata[SPA_BITS-1:0];
				REG_CHANNEL_COUNT:       cc_q  <= cfg_wdata[CC_BITS-1:0];
			endcase
		end
	end

	msa_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (acc_cmd),
		.sample (s_tdata[SAMPLE_BITS-1:0]),
		.busy   (acc_busy),
		.sum    (acc_sum)
	);

	msa_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_sum),
		.divisor  (block_len),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		acc_cmd   = '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					acc_cmd.load = 1'b1;
					state_d      = ST_ACCUM;
				end
			end
			ST_ACCUM: begin
				if (!acc_busy) begin
					if (block_end) begin
						div_start     = 1'b1;
						acc_cmd.clear = 1'b1;
						state_d       = ST_DIVIDE;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DIVIDE: begin
				if (!div_busy && (!m_tvalid_q || m_tready)) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q    <= '0;
			slot_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_ACCUM && !acc_busy) begin
				taken_q <= block_end ? '0 : taken_q + 1'b1;
			end
			if (out_load) begin
				slot_q     <= run_end ? '0 : slot_q + 1'b1;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_cmd.load) begin
			chan_q <= s_tuser;
		end
		if (out_load) begin
			avg_q   <= average;
			ochan_q <= chan_q;
			oslot_q <= slot_q;
			olast_q <= run_end;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_DATA_BITS'(avg_q);
	assign m_tuser  = {oslot_q, ochan_q};
	assign m_tlast  = olast_q;

	`ASSERT_IMPL(a_div_start_acc_idle, div_start, !acc_busy && !div_busy, "divider started while busy")
	`ASSERT_IMPL(a_load_free, out_load, !m_tvalid_q || m_tready, "result overwrote pending output")
	`ASSERT_IMPL(a_accept_idle, s_tvalid && s_tready, !acc_busy && !div_busy, "input taken while busy")
	`ASSERT_CLK(a_taken_range, {1'b0, taken_q} < SPA_BITS'(MAX_AVERAGE), "sample count out of range")

endmodule

[src/msa_accum.sv]
module msa_accum (
	input  logic                             clk,
	input  logic                             arst_n,
	input  msa_pkg::acc_cmd_t                cmd,
	input  logic [msa_pkg::SAMPLE_BITS-1:0]  sample,
	output logic                             busy,
	output logic [msa_pkg::SUM_BITS-1:0]     sum
);
	import msa_pkg::*;

	logic [SUM_BITS-1:0]       sum_q;
	logic [SUM_BITS-1:0]       addend_q;
	logic                      carry_q;
	logic [DIGIT_CNT_BITS-1:0] digit_q;
	logic                      busy_q;
	logic [DIGIT_BITS:0]       digit_sum;

	assign digit_sum = {1'b0, sum_q[DIGIT_BITS-1:0]} + {1'b0, addend_q[DIGIT_BITS-1:0]}
		+ {{DIGIT_BITS{1'b0}}, carry_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			carry_q <= 1'b0;
			digit_q <= '0;
			busy_q  <= 1'b0;
		end else if (cmd.clear) begin
			sum_q <= '0;
		end else if (cmd.load) begin
			busy_q  <= 1'b1;
			carry_q <= 1'b0;
			digit_q <= DIGIT_CNT_BITS'(SUM_DIGITS - 1);
		end else if (busy_q) begin
			// rotate one digit per cycle, sum digit enters at the top
			sum_q   <= {digit_sum[DIGIT_BITS-1:0], sum_q[SUM_BITS-1:DIGIT_BITS]};
			carry_q <= digit_sum[DIGIT_BITS];
			digit_q <= digit_q - 1'b1;
			if (digit_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addend_q <= SUM_BITS'(sample);
		end else if (busy_q) begin
			addend_q <= addend_q >> DIGIT_BITS;
		end
	end

	assign busy = busy_q;
	assign sum  = sum_q;

endmodule

[src/msa_divider.sv]
module msa_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [msa_pkg::SUM_BITS-1:0]  dividend,
	input  logic [msa_pkg::SPA_BITS-1:0]  divisor,
	output logic                          busy,
	output logic [msa_pkg::SUM_BITS-1:0]  quotient
);
	import msa_pkg::*;

	logic [SUM_BITS-1:0]     quo_q;
	logic [SPA_BITS-1:0]     rem_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    busy_q;
	logic [SPA_BITS:0]       trial;
	logic [SPA_BITS:0]       diff;
	logic                    fits;

	assign trial = {rem_q, quo_q[SUM_BITS-1]};
	assign fits  = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_BITS'(DIV_STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// restoring division: one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_BITS-2:0], fits};
			rem_q <= fits ? diff[SPA_BITS-1:0] : trial[SPA_BITS-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule
